[rtl/assert_macros.svh]
// Assertion macros shared by the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/ipsp_pkg.sv]
// Types, codes and helper functions for the IPv4 dotted text parser.
// No dependencies.
package ipsp_pkg;

  localparam logic [7:0] OctetMax  = 8'd255;
  localparam logic [5:0] PrefixMin = 6'd8;
  localparam logic [5:0] PrefixMax = 6'd31;
  localparam logic [7:0] ChrZero   = 8'h30;
  localparam logic [7:0] ChrNine   = 8'h39;
  localparam logic [7:0] ChrDot    = 8'h2e;

  typedef enum logic [1:0] {
    ACT_ADDR   = 2'd0,
    ACT_MASK   = 2'd1,
    ACT_PREFIX = 2'd2,
    ACT_NONE   = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_ADDR = 2'd1,
    ERR_MASK = 2'd2
  } err_e;

  typedef enum logic {
    KIND_ADDR = 1'b0,
    KIND_MASK = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    JOB_TEXT_OK  = 2'd0,
    JOB_TEXT_BAD = 2'd1,
    JOB_PREFIX   = 2'd2
  } job_e;

  typedef struct packed {
    job_e        cls;
    kind_e       kind;
    logic [31:0] value;
    logic [5:0]  plen;
  } job_t;

  function automatic logic [3:0] popcnt8(input logic [7:0] b);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'd0, b[i]};
    end
    return n;
  endfunction

  function automatic logic [5:0] popcnt32(input logic [31:0] w);
    logic [5:0] s;
    s = {2'd0, popcnt8(w[31:24])} + {2'd0, popcnt8(w[23:16])}
      + {2'd0, popcnt8(w[15:8])} + {2'd0, popcnt8(w[7:0])};
    return s;
  endfunction

endpackage

[rtl/ipsp_if.sv]
// Valid/ready channel interfaces for input and result words.
// No dependencies.
interface ipsp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] char_code;
  logic       last_char;
  logic [5:0] prefix_len;

  modport source (output valid, action, char_code, last_char, prefix_len, input ready);
  modport sink   (input valid, action, char_code, last_char, prefix_len, output ready);
endinterface

interface ipsp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] value;
  logic [31:0] subnet;
  logic [5:0]  ones_count;
  logic [1:0]  error;

  modport source (output valid, kind, value, subnet, ones_count, error, input ready);
  modport sink   (input valid, kind, value, subnet, ones_count, error, output ready);
endinterface

[rtl/ipv4_dotted_subnet_parser_unit.sv]
// IPv4 dotted address / subnet mask parser, top level.
// Depends on ipsp_pkg, ipsp_if, ipsp_front, ipsp_queue, ipsp_back and assert_macros.svh.
//
// Takes one word per cycle: a character of an address or mask text, or a mask prefix
// length. The word that ends a text or carries a prefix gives a result word, which passes
// through the two-entry job queue and then the output register; characters inside a
// text give no result. Sustained rate is one word per cycle, limited only by the output
// register draining; a stalled output fills the queue and then drops ready.
// Good address results update the stored address used for later subnet results, in order.
`include "assert_macros.svh"
module ipv4_dotted_subnet_parser_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  ipsp_in_if.sink    in_i,
  ipsp_out_if.source out_o
);
  import ipsp_pkg::*;

  logic push, pop, q_full, q_avail;
  job_t job_in, job_out;

  ipsp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .q_full_i(q_full),
    .push_o  (push),
    .job_o   (job_in)
  );

  ipsp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .full_o (q_full),
    .pop_i  (pop),
    .avail_o(q_avail),
    .job_o  (job_out)
  );

  ipsp_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .avail_i(q_avail),
    .job_i  (job_out),
    .pop_o  (pop),
    .out_o  (out_o)
  );

  `ASSERT_ALWAYS(a_no_overflow, clk_i, rst_ni, !(push && q_full), "job pushed into full queue")
  `ASSERT_ALWAYS(a_no_underflow, clk_i, rst_ni, !(pop && !q_avail), "job popped from empty queue")
  `ASSERT_IMPLIES(a_ones_match, clk_i, rst_ni, out_o.valid && out_o.kind == KIND_MASK && out_o.error == ERR_NONE, out_o.ones_count == 6'($countones(out_o.value)), "ones count mismatch")
  `ASSERT_IMPLIES(a_err_zero, clk_i, rst_ni, out_o.valid && out_o.error != ERR_NONE, out_o.value == 32'd0 && out_o.subnet == 32'd0 && out_o.ones_count == 6'd0, "error result not zeroed")
  `ASSERT_IMPLIES(a_addr_subnet, clk_i, rst_ni, out_o.valid && out_o.kind == KIND_ADDR, out_o.subnet == 32'd0 && out_o.ones_count == 6'd0, "address result carries subnet")

endmodule

[rtl/ipsp_front.sv]
// Front end: accepts words, runs the text parse state, emits one job per text end or prefix.
// Depends on ipsp_pkg and ipsp_if.
module ipsp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  ipsp_in_if.sink       in_i,
  input  logic          q_full_i,
  output logic          push_o,
  output ipsp_pkg::job_t job_o
);
  import ipsp_pkg::*;

  logic [9:0]  accum_q, accum_d, accum_t;
  logic [2:0]  digits_q, digits_d, digits_t;
  logic [1:0]  dots_q, dots_d, dots_t;
  logic        perr_q, perr_d, perr_t;
  logic [31:0] part_q, part_d, part_t;
  logic        accept, is_text, is_digit, text_ok;
  act_e        act;
  logic [9:0]  digit_val;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign act        = act_e'(in_i.action);
  assign is_text    = (act == ACT_ADDR) || (act == ACT_MASK);
  assign is_digit   = in_i.char_code inside {[ChrZero:ChrNine]};
  assign digit_val  = {2'd0, in_i.char_code - ChrZero};

  // one character of the text
  always_comb begin
    accum_t  = accum_q;
    digits_t = digits_q;
    dots_t   = dots_q;
    perr_t   = perr_q;
    part_t   = part_q;
    if (is_digit) begin
      if (digits_q >= 3'd3) begin
        perr_t = 1'b1;
      end else begin
        accum_t  = (accum_q << 3) + (accum_q << 1) + digit_val;
        digits_t = digits_q + 3'd1;
      end
    end else if (in_i.char_code == ChrDot) begin
      if (digits_q == 3'd0 || accum_q > {2'd0, OctetMax} || dots_q == 2'd3) begin
        perr_t = 1'b1;
      end else begin
        part_t   = {part_q[23:0], accum_q[7:0]};
        dots_t   = dots_q + 2'd1;
        accum_t  = '0;
        digits_t = '0;
      end
    end else begin
      perr_t = 1'b1;
    end
  end

  assign text_ok = !perr_t && dots_t == 2'd3 && digits_t != 3'd0
                && accum_t <= {2'd0, OctetMax};

  always_comb begin
    accum_d  = accum_q;
    digits_d = digits_q;
    dots_d   = dots_q;
    perr_d   = perr_q;
    part_d   = part_q;
    if (accept && is_text) begin
      if (in_i.last_char) begin
        accum_d  = '0;
        digits_d = '0;
        dots_d   = '0;
        perr_d   = 1'b0;
        part_d   = '0;
      end else begin
        accum_d  = accum_t;
        digits_d = digits_t;
        dots_d   = dots_t;
        perr_d   = perr_t;
        part_d   = part_t;
      end
    end
  end

  always_comb begin
    push_o      = accept && ((act == ACT_PREFIX) || (is_text && in_i.last_char));
    job_o.plen  = in_i.prefix_len;
    job_o.value = {part_t[23:0], accum_t[7:0]};
    job_o.kind  = (act == ACT_ADDR) ? KIND_ADDR : KIND_MASK;
    if (act == ACT_PREFIX) begin
      job_o.cls = JOB_PREFIX;
    end else if (text_ok) begin
      job_o.cls = JOB_TEXT_OK;
    end else begin
      job_o.cls = JOB_TEXT_BAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q  <= '0;
      digits_q <= '0;
      dots_q   <= '0;
      perr_q   <= 1'b0;
      part_q   <= '0;
    end else begin
      accum_q  <= accum_d;
      digits_q <= digits_d;
      dots_q   <= dots_d;
      perr_q   <= perr_d;
      part_q   <= part_d;
    end
  end

endmodule

[rtl/ipsp_queue.sv]
// Two-entry job queue between front and back end.
// Depends on ipsp_pkg.
module ipsp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ipsp_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           avail_o,
  output ipsp_pkg::job_t job_o
);
  import ipsp_pkg::*;

  job_t       slot_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign avail_o = cnt_q != 2'd0;
  assign job_o   = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q ^ push_i;
    rd_d  = rd_q ^ pop_i;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

[rtl/ipsp_back.sv]
// Back end: turns jobs into result words, holds the stored address and the output register.
// Depends on ipsp_pkg and ipsp_if.
module ipsp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           avail_i,
  input  ipsp_pkg::job_t job_i,
  output logic           pop_o,
  ipsp_out_if.source     out_o
);
  import ipsp_pkg::*;

  logic        ovalid_q, ovalid_d;
  logic        kind_q, kind_d;
  logic [31:0] value_q, value_d, subnet_q, subnet_d;
  logic [5:0]  ones_q, ones_d;
  err_e        err_q, err_d;
  logic [31:0] addr_q, addr_d;
  logic [31:0] inv, pmask;
  logic        contig;

  assign pop_o  = avail_i && (!ovalid_q || out_o.ready);
  assign inv    = ~job_i.value;
  assign contig = (inv & (inv + 32'd1)) == 32'd0;
  assign pmask  = 32'hffff_ffff << (6'd32 - job_i.plen);

  always_comb begin
    kind_d   = job_i.kind;
    value_d  = '0;
    subnet_d = '0;
    ones_d   = '0;
    err_d    = ERR_NONE;
    addr_d   = addr_q;
    case (job_i.cls)
      JOB_TEXT_BAD: begin
        err_d = ERR_ADDR;
      end
      JOB_TEXT_OK: begin
        if (job_i.kind == KIND_ADDR) begin
          value_d = job_i.value;
          addr_d  = job_i.value;
        end else if (!contig) begin
          err_d = ERR_MASK;
        end else begin
          value_d  = job_i.value;
          subnet_d = addr_q & job_i.value;
          ones_d   = popcnt32(job_i.value);
        end
      end
      JOB_PREFIX: begin
        kind_d = KIND_MASK;
        if (job_i.plen < PrefixMin || job_i.plen > PrefixMax) begin
          err_d = ERR_MASK;
        end else begin
          value_d  = pmask;
          subnet_d = addr_q & pmask;
          ones_d   = job_i.plen;
        end
      end
      default: begin
        err_d = ERR_ADDR;
      end
    endcase
    if (!pop_o) begin
      addr_d = addr_q;
    end
  end

  assign ovalid_d = pop_o || (ovalid_q && !out_o.ready);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q   <= kind_d;
      value_q  <= value_d;
      subnet_q <= subnet_d;
      ones_q   <= ones_d;
      err_q    <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      addr_q   <= '0;
    end else begin
      ovalid_q <= ovalid_d;
      addr_q   <= addr_d;
    end
  end

  assign out_o.valid      = ovalid_q;
  assign out_o.kind       = kind_q;
  assign out_o.value      = value_q;
  assign out_o.subnet     = subnet_q;
  assign out_o.ones_count = ones_q;
  assign out_o.error      = err_q;

endmodule

[tb/sv/tb_ipv4_dotted_subnet_parser_unit.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the IPv4 dotted address / subnet mask parser.
// Depends on ipsp_pkg, ipsp_if and ipv4_dotted_subnet_parser_unit.
module tb_ipv4_dotted_subnet_parser_unit;
  import ipsp_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned PrintCap = 40;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] value;
    logic [31:0] subnet;
    logic [5:0]  ones;
    err_e        err;
  } parse_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic holding = 1'b0;
  bit src_idle = 1'b0;
  bit sink_idle = 1'b0;
  bit sprinkle = 1'b0;
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;

  // text parse state and last good address
  logic [9:0]  txt_accum;
  logic [2:0]  txt_digits;
  logic [1:0]  txt_dots;
  logic        txt_bad;
  logic [31:0] txt_partial;
  logic [31:0] stored_addr;

  parse_result_t expected_results[$];
  logic [7:0]    text_buf[$];

  ipsp_in_if  in_bus ();
  ipsp_out_if res_bus ();

  ipv4_dotted_subnet_parser_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (res_bus)
  );

  always #4 clk_i = ~clk_i;

  function automatic void clear_text();
    txt_accum = '0;
    txt_digits = '0;
    txt_dots = '0;
    txt_bad = 1'b0;
    txt_partial = '0;
  endfunction

  function automatic void take_char(logic [7:0] ch);
    if (ch >= ChrZero && ch <= ChrNine) begin
      if (txt_digits >= 3'd3) begin
        txt_bad = 1'b1;
      end else begin
        txt_accum = txt_accum * 10'd10 + {2'b00, ch - ChrZero};
        txt_digits = txt_digits + 3'd1;
      end
    end else if (ch == ChrDot) begin
      if (txt_digits == 3'd0 || txt_accum > {2'b00, OctetMax} || txt_dots == 2'd3) begin
        txt_bad = 1'b1;
      end else begin
        txt_partial = {txt_partial[23:0], txt_accum[7:0]};
        txt_dots = txt_dots + 2'd1;
        txt_accum = '0;
        txt_digits = '0;
      end
    end else begin
      txt_bad = 1'b1;
    end
  endfunction

  function automatic void predict_word(act_e act, logic [7:0] ch, logic last,
                                       logic [5:0] plen);
    parse_result_t r;
    logic [31:0]   word;
    logic [31:0]   inv;
    logic          ok;
    r = '0;
    case (act)
      ACT_PREFIX: begin
        r.kind = KIND_MASK;
        if (plen < PrefixMin || plen > PrefixMax) begin
          r.err = ERR_MASK;
        end else begin
          word = 32'hFFFF_FFFF << (32 - plen);
          r.value = word;
          r.subnet = stored_addr & word;
          r.ones = plen;
        end
        expected_results.push_back(r);
      end
      ACT_ADDR, ACT_MASK: begin
        take_char(ch);
        if (last) begin
          ok = !txt_bad && txt_dots == 2'd3 && txt_digits != 3'd0 &&
               txt_accum <= {2'b00, OctetMax};
          word = {txt_partial[23:0], txt_accum[7:0]};
          clear_text();
          r.kind = (act == ACT_ADDR) ? KIND_ADDR : KIND_MASK;
          inv = ~word;
          if (!ok) begin
            r.err = ERR_ADDR;
          end else if (act == ACT_ADDR) begin
            stored_addr = word;
            r.value = word;
          end else if ((inv & (inv + 32'd1)) != 32'd0) begin
            r.err = ERR_MASK;
          end else begin
            r.value = word;
            r.subnet = stored_addr & word;
            r.ones = 6'($countones(word));
          end
          expected_results.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < PrintCap) begin
      $display("%0t MISMATCH %s: got %h, want %h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  task automatic check_result();
    parse_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result word, value", res_bus.value, 32'd0);
    end else begin
      want = expected_results.pop_front();
      if (res_bus.kind !== want.kind) report_mismatch("kind", res_bus.kind, want.kind);
      if (res_bus.value !== want.value) report_mismatch("value", res_bus.value, want.value);
      if (res_bus.subnet !== want.subnet)
        report_mismatch("subnet", res_bus.subnet, want.subnet);
      if (res_bus.ones_count !== want.ones)
        report_mismatch("ones_count", res_bus.ones_count, want.ones);
      if (res_bus.error !== want.err) report_mismatch("error", res_bus.error, want.err);
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: random stalls, plus the long hold-off
  initial begin : result_sink
    int unsigned stall;
    stall = 0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_bus.valid && res_bus.ready) check_result();
      if (holding) begin
        res_bus.ready <= 1'b0;
      end else begin
        if (sink_idle && stall == 0 && $urandom_range(0, 3) == 0) stall = pick_gap();
        if (stall != 0) begin
          stall--;
          res_bus.ready <= 1'b0;
        end else begin
          res_bus.ready <= 1'b1;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles <= CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  task automatic send_word(act_e act, logic [7:0] ch, logic last, logic [5:0] plen);
    int unsigned gap;
    gap = src_idle ? pick_gap() : 0;
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.action <= act;
    in_bus.char_code <= ch;
    in_bus.last_char <= last;
    in_bus.prefix_len <= plen;
    do begin
      @(posedge clk_i);
    end while (!in_bus.ready);
    predict_word(act, ch, last, plen);
    if (act != ACT_NONE) words_sent++;
  endtask

  task automatic send_noise_word();
    send_word(ACT_NONE, 8'($urandom), 1'($urandom), 6'($urandom));
  endtask

  task automatic wait_drain();
    in_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  function automatic void push_dotted(logic [31:0] v, bit pad);
    for (int k = 3; k >= 0; k--) begin
      if (pad && $urandom_range(0, 1) == 1) push_str($sformatf("%03d", v[8*k +: 8]));
      else push_str($sformatf("%0d", v[8*k +: 8]));
      if (k != 0) text_buf.push_back(ChrDot);
    end
  endfunction

  function automatic logic [7:0] rand_octet();
    case ($urandom_range(0, 2))
      0: return 8'($urandom_range(0, 9));
      1: return 8'($urandom_range(10, 99));
      default: return 8'($urandom_range(100, 255));
    endcase
  endfunction

  function automatic logic [31:0] rand_addr();
    return {rand_octet(), rand_octet(), rand_octet(), rand_octet()};
  endfunction

  function automatic void mutate_text();
    int unsigned pos;
    int unsigned big_at;
    pos = $urandom_range(0, text_buf.size() - 1);
    case ($urandom_range(0, 7))
      0: text_buf.insert(pos, 8'($urandom));
      1: if (text_buf.size() > 1) text_buf.delete(pos);
      2: text_buf[pos] = 8'($urandom);
      3: text_buf.insert(pos, ChrZero + 8'($urandom_range(0, 9)));
      4: text_buf.insert(pos, ChrDot);
      5: begin
        text_buf.push_back(ChrDot);
        push_str($sformatf("%0d", rand_octet()));
      end
      6: text_buf.push_back(ChrDot);
      default: begin
        text_buf.delete();
        big_at = $urandom_range(0, 3);
        for (int k = 0; k < 4; k++) begin
          if (k == big_at) push_str($sformatf("%0d", $urandom_range(256, 999)));
          else push_str($sformatf("%0d", rand_octet()));
          if (k != 3) text_buf.push_back(ChrDot);
        end
      end
    endcase
  endfunction

  task automatic send_text(act_e act, bit mixed);
    act_e a;
    for (int i = 0; i < text_buf.size(); i++) begin
      a = act;
      if (mixed && i != text_buf.size() - 1) a = $urandom_range(0, 1) ? ACT_MASK : ACT_ADDR;
      if (sprinkle && $urandom_range(0, 31) == 0) send_noise_word();
      send_word(a, text_buf[i], i == text_buf.size() - 1, 6'($urandom));
    end
    text_buf.delete();
  endtask

  task automatic send_str(string s, act_e act);
    push_str(s);
    send_text(act, 1'b0);
  endtask

  task automatic send_prefix(logic [5:0] plen);
    send_word(ACT_PREFIX, 8'($urandom), 1'($urandom), plen);
  endtask

  task automatic send_random_entry();
    int unsigned sel;
    int unsigned n;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      push_dotted(rand_addr(), $urandom_range(0, 7) == 0);
      send_text(ACT_ADDR, $urandom_range(0, 9) == 0);
    end else if (sel < 62) begin
      n = $urandom_range(0, 32);
      push_dotted(32'hFFFF_FFFF << (32 - n), $urandom_range(0, 7) == 0);
      send_text(ACT_MASK, $urandom_range(0, 9) == 0);
    end else if (sel < 67) begin
      push_dotted(rand_addr(), 1'b0);
      send_text(ACT_MASK, 1'b0);
    end else if (sel < 80) begin
      if ($urandom_range(0, 1) == 1) send_prefix(6'($urandom_range(8, 31)));
      else send_prefix(6'($urandom_range(0, 63)));
    end else if (sel < 94) begin
      push_dotted(rand_addr(), 1'b0);
      mutate_text();
      send_text($urandom_range(0, 1) ? ACT_MASK : ACT_ADDR, 1'b0);
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) text_buf.push_back(8'($urandom));
      send_text($urandom_range(0, 1) ? ACT_MASK : ACT_ADDR, 1'b0);
    end
  endtask

  task automatic test_address_limits();
    send_str("0.0.0.0", ACT_ADDR);
    send_str("255.255.255.255", ACT_ADDR);
    send_str("010.002.099.200", ACT_ADDR);
  endtask

  task automatic test_prefix_range();
    send_prefix(PrefixMin);
    send_prefix(PrefixMax);
    send_prefix(6'd7);
    send_prefix(6'd32);
    send_prefix(6'd0);
    send_prefix(6'd63);
    send_prefix(6'd20);
  endtask

  task automatic test_mask_text();
    send_str("255.255.0.0", ACT_MASK);
    send_str("0.0.0.0", ACT_MASK);
    send_str("255.255.255.255", ACT_MASK);
    send_str("255.0.255.0", ACT_MASK);
    push_str("192.168.37.9");
    send_text(ACT_ADDR, 1'b1);
    push_str("255.255.255.128");
    send_text(ACT_MASK, 1'b1);
  endtask

  task automatic test_malformed_text();
    send_str("1.2.3.4a", ACT_ADDR);
    send_str("1234.5.6.7", ACT_ADDR);
    send_str("1.2.3.4567", ACT_ADDR);
    send_str("256.1.1.1", ACT_ADDR);
    send_str(".1.1.1", ACT_ADDR);
    send_str("1..2.3", ACT_ADDR);
    send_str("1.2.3.4.5", ACT_ADDR);
    send_str("1.2.3", ACT_ADDR);
    send_str("1.2.3.256", ACT_ADDR);
    send_str("1.2.3.", ACT_ADDR);
    send_str("255.x.0.0", ACT_MASK);
    send_word(ACT_NONE, ChrDot, 1'b1, 6'd16);
    send_str("9.8.7.6", ACT_ADDR);
  endtask

  task automatic test_random_traffic(int unsigned count);
    int unsigned start;
    start = words_sent;
    src_idle = 1'b1;
    sink_idle = 1'b1;
    sprinkle = 1'b1;
    while (words_sent < start + count) send_random_entry();
  endtask

  task automatic test_full_rate(int unsigned count);
    int unsigned start;
    start = words_sent;
    src_idle = 1'b0;
    sink_idle = 1'b0;
    while (words_sent < start + count) send_random_entry();
  endtask

  // result side blocked while words keep coming, then the sender waits for all results
  task automatic test_output_hold();
    int unsigned start;
    start = words_sent;
    src_idle = 1'b0;
    sink_idle = 1'b0;
    fork
      begin
        holding <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        holding <= 1'b0;
      end
    join_none
    while (words_sent < start + 150) begin
      if ($urandom_range(0, 1) == 1) send_prefix(6'($urandom_range(0, 63)));
      else send_random_entry();
    end
    wait_drain();
  endtask

  initial begin : stimulus
    in_bus.valid <= 1'b0;
    in_bus.action <= ACT_NONE;
    in_bus.char_code <= 8'd0;
    in_bus.last_char <= 1'b0;
    in_bus.prefix_len <= 6'd0;
    clear_text();
    stored_addr = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_address_limits();
    test_prefix_range();
    test_mask_text();
    test_malformed_text();
    test_random_traffic(900);
    test_output_hold();
    test_full_rate(250);
    test_random_traffic(300);
    wait_drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
